// ===== hw/rtl/obd_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// obd_pkg
// Shared types, constants and the CRC-8 step for the diagnostic frame builder.
// ----------------------------------------------------------------------------
package obd_pkg;

  localparam int unsigned BYTE_W   = 8;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned SLOT_W   = 3;

  typedef enum logic [1:0] {
    MODE_ISO9141   = 2'd0,
    MODE_ISO14230  = 2'd1,
    MODE_J1850_VPW = 2'd2,
    MODE_J1850_PWM = 2'd3
  } obd_mode_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PROTOCOL_MODE     = 3'd0,
    REG_INSERT_HEADER     = 3'd1,
    REG_HEADER_BYTE_ONE   = 3'd2,
    REG_HEADER_BYTE_TWO   = 3'd3,
    REG_HEADER_BYTE_THREE = 3'd4
  } obd_reg_e;

  localparam logic [BYTE_W-1:0] HDR_ONE_RST   = 8'h68;
  localparam logic [BYTE_W-1:0] HDR_TWO_RST   = 8'h6A;
  localparam logic [BYTE_W-1:0] HDR_THREE_RST = 8'hF1;
  localparam logic [BYTE_W-1:0] CRC_INIT      = 8'hFF;
  localparam logic [BYTE_W-1:0] SUM_INIT      = 8'h00;
  localparam logic [BYTE_W-1:0] FMT_TOP_MASK  = 8'hC0;
  localparam logic [BYTE_W-1:0] FMT_LEN_MASK  = 8'h0F;
  localparam logic [BYTE_W-1:0] FMT_LEN_MAX   = 8'd63;

  typedef struct packed {
    obd_mode_e         protocol_mode;
    logic              insert_header;
    logic [BYTE_W-1:0] header_byte_one;
    logic [BYTE_W-1:0] header_byte_two;
    logic [BYTE_W-1:0] header_byte_three;
  } obd_cfg_t;

  typedef struct packed {
    logic [BYTE_W-1:0] payload_byte;
    logic              first_of_message;
    logic              last_of_message;
    logic [BYTE_W-1:0] payload_count;
  } obd_item_t;

  typedef struct packed {
    logic [BYTE_W-1:0] frame_byte;
    logic              end_of_frame;
  } obd_out_t;

  // CRC-8, poly 0x1D, MSB first
  function automatic logic [BYTE_W-1:0] obd_crc8_update(logic [BYTE_W-1:0] crc,
                                                        logic [BYTE_W-1:0] val);
    logic [BYTE_W-1:0] c;
    logic [BYTE_W-1:0] v;
    c = crc;
    v = val;
    for (int i = 0; i < BYTE_W; i++) begin
      if (v[BYTE_W-1] ^ c[BYTE_W-1]) begin
        c = {c[BYTE_W-2:0], 1'b0} ^ 8'h1D;
      end else begin
        c = {c[BYTE_W-2:0], 1'b0};
      end
      v = {v[BYTE_W-2:0], 1'b0};
    end
    return c;
  endfunction

endpackage

// ===== hw/rtl/obd_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// obd_if
// Valid/ready stream interfaces for payload items and frame bytes.
// ----------------------------------------------------------------------------
interface obd_in_if;
  logic                      valid;
  logic                      ready;
  logic [obd_pkg::BYTE_W-1:0] payload_byte;
  logic                      first_of_message;
  logic                      last_of_message;
  logic [obd_pkg::BYTE_W-1:0] payload_count;

  modport source (output valid, output payload_byte, output first_of_message,
                  output last_of_message, output payload_count, input ready);
  modport sink   (input valid, input payload_byte, input first_of_message,
                  input last_of_message, input payload_count, output ready);
endinterface

interface obd_out_if;
  logic                      valid;
  logic                      ready;
  logic [obd_pkg::BYTE_W-1:0] frame_byte;
  logic                      end_of_frame;

  modport source (output valid, output frame_byte, output end_of_frame, input ready);
  modport sink   (input valid, input frame_byte, input end_of_frame, output ready);
endinterface

// ===== hw/rtl/obd_cfg_regs.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// obd_cfg_regs
// Configuration register file, write-only.
// ----------------------------------------------------------------------------
module obd_cfg_regs (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [obd_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [obd_pkg::BYTE_W-1:0]       cfg_wdata_i,
  output obd_pkg::obd_cfg_t                cfg_o
);
  import obd_pkg::*;

  obd_cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (obd_reg_e'(cfg_idx_i))
        REG_PROTOCOL_MODE:     cfg_d.protocol_mode     = obd_mode_e'(cfg_wdata_i[1:0]);
        REG_INSERT_HEADER:     cfg_d.insert_header     = cfg_wdata_i[0];
        REG_HEADER_BYTE_ONE:   cfg_d.header_byte_one   = cfg_wdata_i;
        REG_HEADER_BYTE_TWO:   cfg_d.header_byte_two   = cfg_wdata_i;
        REG_HEADER_BYTE_THREE: cfg_d.header_byte_three = cfg_wdata_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.protocol_mode     <= MODE_ISO9141;
      cfg_q.insert_header     <= 1'b1;
      cfg_q.header_byte_one   <= HDR_ONE_RST;
      cfg_q.header_byte_two   <= HDR_TWO_RST;
      cfg_q.header_byte_three <= HDR_THREE_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ===== hw/rtl/obd_byte_seq.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// obd_byte_seq
// Holds one payload item and steps through its frame bytes (header, payload,
// checksum), one per cycle unless stalled, keeping the running sum and CRC.
// ----------------------------------------------------------------------------
module obd_byte_seq (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  obd_pkg::obd_cfg_t  cfg_i,
  obd_in_if.sink             item_i,
  output logic               byte_valid_o,
  output obd_pkg::obd_out_t  byte_o,
  input  logic               byte_ready_i
);
  import obd_pkg::*;

  obd_item_t         item_q;
  logic              item_valid_q, item_valid_d;
  logic [SLOT_W-1:0] idx_q, idx_d;
  logic [BYTE_W-1:0] sum_q, sum_d;
  logic [BYTE_W-1:0] crc_q, crc_d;
  logic              in_frame_q, in_frame_d;

  logic              item_accept;
  logic              drop;
  logic              hdr_on;
  logic [BYTE_W-1:0] fmt_top;
  logic              sep_len;
  logic [BYTE_W-1:0] hdr [4];
  logic [SLOT_W-1:0] hdr_n;
  logic [SLOT_W-1:0] slot_n;
  logic              last_slot;
  logic              restart;
  logic [BYTE_W-1:0] eff_sum;
  logic [BYTE_W-1:0] eff_crc;
  logic [BYTE_W-1:0] ck;
  logic              fire;
  logic              item_done;

  // header layout
  always_comb begin
    hdr_on  = item_q.first_of_message && cfg_i.insert_header;
    fmt_top = cfg_i.header_byte_one & FMT_TOP_MASK;
    sep_len = (item_q.payload_count > FMT_LEN_MAX) ||
              ((cfg_i.header_byte_one & FMT_LEN_MASK) == '0);
    hdr[0]  = cfg_i.header_byte_one;
    hdr[1]  = cfg_i.header_byte_two;
    hdr[2]  = cfg_i.header_byte_three;
    hdr[3]  = item_q.payload_count;
    hdr_n   = SLOT_W'(3);
    if (cfg_i.protocol_mode == MODE_ISO14230) begin
      hdr[0] = sep_len ? fmt_top : (fmt_top | item_q.payload_count);
      if (fmt_top != '0) begin
        hdr_n = sep_len ? SLOT_W'(4) : SLOT_W'(3);
      end else begin
        hdr[1] = item_q.payload_count;
        hdr_n  = sep_len ? SLOT_W'(2) : SLOT_W'(1);
      end
    end
    if (!hdr_on) begin
      hdr_n = '0;
    end
  end

  assign drop    = !item_q.first_of_message && !in_frame_q;
  assign slot_n  = drop ? '0 : (hdr_n + SLOT_W'(1) + SLOT_W'(item_q.last_of_message));
  assign last_slot = (idx_q == slot_n - SLOT_W'(1));
  assign restart = item_q.first_of_message && (idx_q == '0);
  assign eff_sum = restart ? SUM_INIT : sum_q;
  assign eff_crc = restart ? CRC_INIT : crc_q;
  assign ck      = (cfg_i.protocol_mode == MODE_ISO9141 ||
                    cfg_i.protocol_mode == MODE_ISO14230) ? eff_sum : ~eff_crc;

  always_comb begin
    byte_o.end_of_frame = 1'b0;
    if (idx_q < hdr_n) begin
      byte_o.frame_byte = hdr[idx_q[1:0]];
    end else if (idx_q == hdr_n) begin
      byte_o.frame_byte = item_q.payload_byte;
    end else begin
      byte_o.frame_byte   = ck;
      byte_o.end_of_frame = 1'b1;
    end
  end

  assign byte_valid_o = item_valid_q && !drop;
  assign fire         = byte_valid_o && byte_ready_i;
  assign item_done    = item_valid_q && (drop || (fire && last_slot));
  assign item_i.ready = !item_valid_q || item_done;
  assign item_accept  = item_i.valid && item_i.ready;

  always_comb begin
    item_valid_d = item_valid_q;
    idx_d        = idx_q;
    sum_d        = sum_q;
    crc_d        = crc_q;
    in_frame_d   = in_frame_q;
    if (item_done) begin
      item_valid_d = 1'b0;
      idx_d        = '0;
    end else if (fire) begin
      idx_d = idx_q + SLOT_W'(1);
    end
    if (item_accept) begin
      item_valid_d = 1'b1;
    end
    if (fire) begin
      if (byte_o.end_of_frame) begin
        sum_d      = SUM_INIT;
        crc_d      = CRC_INIT;
        in_frame_d = 1'b0;
      end else begin
        sum_d = eff_sum + byte_o.frame_byte;
        crc_d = obd_crc8_update(eff_crc, byte_o.frame_byte);
        if (restart) begin
          in_frame_d = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_valid_q <= 1'b0;
      idx_q        <= '0;
      sum_q        <= SUM_INIT;
      crc_q        <= CRC_INIT;
      in_frame_q   <= 1'b0;
    end else begin
      item_valid_q <= item_valid_d;
      idx_q        <= idx_d;
      sum_q        <= sum_d;
      crc_q        <= crc_d;
      in_frame_q   <= in_frame_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (item_accept) begin
      item_q.payload_byte     <= item_i.payload_byte;
      item_q.first_of_message <= item_i.first_of_message;
      item_q.last_of_message  <= item_i.last_of_message;
      item_q.payload_count    <= item_i.payload_count;
    end
  end

`ifndef NO_ASSERTIONS
  a_drop_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    item_valid_q && drop |-> !byte_valid_o)
    else $error("dropped item produced a frame byte");

  a_idx_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    byte_valid_o |-> idx_q < slot_n)
    else $error("slot index past end of item");

  a_eof_closes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire && byte_o.end_of_frame |=> !in_frame_q && sum_q == SUM_INIT && crc_q == CRC_INIT)
    else $error("checksum byte did not close the frame");

  a_eof_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire && byte_o.end_of_frame |-> last_slot && item_q.last_of_message)
    else $error("checksum byte not at end of item");
`endif

endmodule

// ===== hw/rtl/obd_out_reg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// obd_out_reg
// Output register stage driving the frame byte stream.
// ----------------------------------------------------------------------------
module obd_out_reg (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               byte_valid_i,
  input  obd_pkg::obd_out_t  byte_i,
  output logic               byte_ready_o,
  obd_out_if.source          frame_o
);
  import obd_pkg::*;

  logic     valid_q, valid_d;
  obd_out_t data_q;
  logic     load;

  assign byte_ready_o = !valid_q || frame_o.ready;
  assign load         = byte_valid_i && byte_ready_o;

  always_comb begin
    valid_d = valid_q;
    if (load) begin
      valid_d = 1'b1;
    end else if (frame_o.ready) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      data_q <= byte_i;
    end
  end

  assign frame_o.valid        = valid_q;
  assign frame_o.frame_byte   = data_q.frame_byte;
  assign frame_o.end_of_frame = data_q.end_of_frame;

endmodule

// ===== hw/rtl/obd_frame_builder_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// obd_frame_builder_unit
// Vehicle diagnostic frame builder: header insertion, payload pass-through and
// trailing checksum (8-bit sum or inverted CRC-8).
// ----------------------------------------------------------------------------
//  port      | dir | transaction
//  item_i    | in  | one payload byte with first/last marks and length
//  frame_o   | out | one frame byte, end_of_frame on the checksum
//  cfg_*     | in  | register write, index and 8-bit data
//
//  Each item yields one frame byte per cycle unless frame_o stalls: 1 for a
//  plain payload byte, up to 6 for a single-byte message with header and
//  checksum. Unframed items are dropped. The byte sequencer sets the rate.
//  Reset clears the running sum, CRC and frame state; registers take defaults.
//  item_i.ready drops while multi-byte items step out or frame_o stalls.
// ----------------------------------------------------------------------------
module obd_frame_builder_unit (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [obd_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [obd_pkg::BYTE_W-1:0]    cfg_wdata_i,
  obd_in_if.sink                        item_i,
  obd_out_if.source                     frame_o
);
  import obd_pkg::*;

  obd_cfg_t cfg;
  logic     byte_valid;
  logic     byte_ready;
  obd_out_t byte_data;

  obd_cfg_regs u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_wdata_i(cfg_wdata_i),
    .cfg_o      (cfg)
  );

  obd_byte_seq u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .item_i      (item_i),
    .byte_valid_o(byte_valid),
    .byte_o      (byte_data),
    .byte_ready_i(byte_ready)
  );

  obd_out_reg u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .byte_valid_i(byte_valid),
    .byte_i      (byte_data),
    .byte_ready_o(byte_ready),
    .frame_o     (frame_o)
  );

endmodule
